// ----- hdl/stc_pkg.sv -----
// ---------------------------------------------------------------------------
// stc_pkg: shared types and constants of the script token scanner
// token kinds, scanner modes, keyword table and the front-to-back word format
// ---------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam int TEXT_BYTES_MAX_DEF = 65536;
    localparam int KEYWORD_COUNT_DEF  = 14;
    localparam int KW_TABLE           = 14;
    localparam int QUEUE_DEPTH        = 4;

    // token kinds
    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_SEMI    = 6'd4;
    localparam logic [5:0] K_COMMA   = 6'd5;
    localparam logic [5:0] K_DOT     = 6'd6;
    localparam logic [5:0] K_MINUS   = 6'd7;
    localparam logic [5:0] K_PLUS    = 6'd8;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_STAR    = 6'd10;
    localparam logic [5:0] K_BANG    = 6'd11;
    localparam logic [5:0] K_BANG_EQ = 6'd12;
    localparam logic [5:0] K_EQUAL   = 6'd13;
    localparam logic [5:0] K_EQ_EQ   = 6'd14;
    localparam logic [5:0] K_LESS    = 6'd15;
    localparam logic [5:0] K_LESS_EQ = 6'd16;
    localparam logic [5:0] K_GREATER = 6'd17;
    localparam logic [5:0] K_GT_EQ   = 6'd18;
    localparam logic [5:0] K_IDENT   = 6'd19;
    localparam logic [5:0] K_STRING  = 6'd20;
    localparam logic [5:0] K_NUMBER  = 6'd21;
    localparam logic [5:0] K_KW0     = 6'd22;
    localparam logic [5:0] K_EOF     = 6'd36;
    localparam logic [5:0] K_ERROR   = 6'd37;

    // error codes
    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_UNEXP   = 2'd1;
    localparam logic [1:0] E_UNTERM  = 2'd2;

    // scanner modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_NUMBER  = 4'd2;
    localparam logic [3:0] M_NUM_DOT = 4'd3;
    localparam logic [3:0] M_FRAC    = 4'd4;
    localparam logic [3:0] M_STRING  = 4'd5;
    localparam logic [3:0] M_COMMENT = 4'd6;
    localparam logic [3:0] M_OP_BANG = 4'd7;
    localparam logic [3:0] M_OP_EQ   = 4'd8;
    localparam logic [3:0] M_OP_LT   = 4'd9;
    localparam logic [3:0] M_OP_GT   = 4'd10;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [1:0]  err;
    } t_token;

    // one word from front to back: up to three tokens of one input byte
    typedef struct packed {
        logic [1:0]       cnt;
        logic [15:0]      line;
        t_token [2:0]     tok;
    } t_bundle;

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] l;
        case (k)
            0: l = 4'd3;   1: l = 4'd4;   2: l = 4'd5;   3: l = 4'd3;
            4: l = 4'd6;   5: l = 4'd8;   6: l = 4'd2;   7: l = 4'd3;
            8: l = 4'd2;   9: l = 4'd5;   10: l = 4'd6;  11: l = 4'd4;
            12: l = 4'd3;  13: l = 4'd5;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    // keyword text, right justified, first character highest
    function automatic logic [63:0] kw_text(input int k);
        logic [63:0] t;
        case (k)
            0: t = 64'("and");      1: t = 64'("else");
            2: t = 64'("false");    3: t = 64'("for");
            4: t = 64'("struct");   5: t = 64'("function");
            6: t = 64'("if");       7: t = 64'("nil");
            8: t = 64'("or");       9: t = 64'("print");
            10: t = 64'("return");  11: t = 64'("true");
            12: t = 64'("var");     13: t = 64'("while");
            default: t = 64'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/script_token_scanner.sv -----
// ---------------------------------------------------------------------------
// script_token_scanner: streaming lexical scanner for a small script language
// one source byte a word in, tokens with kind, offset, length and line out
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake                   payload
//  input    in         i_in_valid / o_in_stall     i_text_byte, i_end_of_text
//  output   out        o_out_valid / i_out_stall   o_token_*, o_error_code,
//                                                  o_last_of_run
//
//  the front accepts one byte every cycle while the word queue has room
//  a byte completes zero to three tokens; the back sends one token a cycle
//  while not stalled, so the sustained rate is one byte a cycle while tokens
//  average one or less; a token goes through front, queue and output register
//  output stall backs up through the queue to o_in_stall; reset is synchronous
//  and returns mode, position, line and keyword candidates to their start
// ---------------------------------------------------------------------------
`default_nettype none

module script_token_scanner
    import stc_pkg::*;
#(
    parameter int TEXT_BYTES_MAX = TEXT_BYTES_MAX_DEF,
    parameter int KEYWORD_COUNT  = KEYWORD_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [5:0]       o_token_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic [15:0]      o_token_line,
    output logic [1:0]       o_error_code,
    output logic             o_last_of_run
);

    // front to queue
    logic    push;
    t_bundle word_in;
    // queue to back
    logic    full;
    logic    empty;
    logic    pop;
    t_bundle head;

    assign o_in_stall = full;

    // classifier: scanner mode, position, line, keyword candidates
    stc_front #(
        .TEXT_BYTES_MAX (TEXT_BYTES_MAX),
        .KEYWORD_COUNT  (KEYWORD_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_full        (full),
        .o_push        (push),
        .o_bundle      (word_in)
    );

    // decoupling queue, words with no tokens are never written
    stc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (word_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // serialiser, marks the final token of each word
    stc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_stall        (i_out_stall),
        .o_valid        (o_out_valid),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_token_line   (o_token_line),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

    // a word is never written into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("word written into full queue");

    // nothing is read from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("word read from empty queue");

    // end of text always closes its word
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == K_EOF) |-> o_last_of_run)
        else $error("end of text token not last of its word");

    // error tokens carry a cause, other tokens none
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_token_kind == K_ERROR) == (o_error_code != E_NONE)))
        else $error("error code does not match token kind");

endmodule

`default_nettype wire

// ----- hdl/stc_front.sv -----
// ---------------------------------------------------------------------------
// stc_front: byte classifier and scanner state
// takes a byte a cycle unless queue is full, forms the tokens it completes
// ---------------------------------------------------------------------------
`default_nettype none

module stc_front
    import stc_pkg::*;
#(
    parameter int TEXT_BYTES_MAX = TEXT_BYTES_MAX_DEF,
    parameter int KEYWORD_COUNT  = KEYWORD_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    input  wire logic        i_full,
    output logic             o_push,
    output t_bundle          o_bundle
);

    localparam int POS_LIMIT_I = (TEXT_BYTES_MAX - 1) < 65535 ? (TEXT_BYTES_MAX - 1) : 65535;
    localparam logic [15:0] POS_LIMIT = 16'(POS_LIMIT_I);
    localparam int KW_USED = KEYWORD_COUNT < KW_TABLE ? KEYWORD_COUNT : KW_TABLE;
    localparam logic [13:0] KW_MASK = 14'((32'd1 << KW_USED) - 32'd1);

    logic [3:0]  r_mode, n_mode;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_start, n_start;
    logic [15:0] r_line, n_line;
    logic [13:0] r_cand, n_cand;
    t_bundle     b;
    logic        accept;

    function automatic t_token mk(input logic [5:0] kind, input logic [15:0] st,
                                  input logic [15:0] ln, input logic [1:0] er);
        t_token t;
        t.kind  = kind;
        t.start = st;
        t.len   = ln;
        t.err   = er;
        return t;
    endfunction

    function automatic t_bundle add(input t_bundle bi, input t_token t);
        t_bundle bo;
        bo = bi;
        if (bi.cnt != 2'd3) begin
            bo.tok[bi.cnt] = t;
            bo.cnt         = bi.cnt + 2'd1;
        end
        return bo;
    endfunction

    function automatic logic [13:0] filter(input logic [13:0] cand, input logic [15:0] idx,
                                           input logic [7:0] c);
        logic [13:0] keep;
        logic [3:0]  l;
        logic [2:0]  sh;
        logic [63:0] tx;
        keep = '0;
        for (int k = 0; k < KW_USED; k++) begin
            l  = kw_len(k);
            tx = kw_text(k);
            sh = 3'(l - 4'd1 - {1'b0, idx[2:0]});
            if (cand[k] && idx < {12'd0, l} && tx[{sh, 3'd0} +: 8] == c)
                keep[k] = 1'b1;
        end
        return keep;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [13:0] cand, input logic [15:0] ln);
        logic [5:0] kd;
        kd = K_IDENT;
        for (int k = KW_USED - 1; k >= 0; k--) begin
            if (cand[k] && ln == {12'd0, kw_len(k)})
                kd = K_KW0 + 6'(k);
        end
        return kd;
    endfunction

    always_comb begin
        logic [15:0] adv;
        logic [15:0] len;
        logic [5:0]  pk;
        logic        done;
        logic        alpha;
        logic        digit;
        adv   = (r_pos < POS_LIMIT) ? r_pos + 16'd1 : r_pos;
        len   = (r_pos >= r_start) ? r_pos - r_start : 16'd0;
        alpha = (i_text_byte inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || i_text_byte == 8'h5f;
        digit = i_text_byte inside {[8'h30:8'h39]};
        pk    = 6'h3f;
        done  = 1'b0;
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_line  = r_line;
        n_cand  = r_cand;
        b       = '0;
        b.line  = r_line;

        if (!i_end_of_text) begin
            case (r_mode)
                M_IDENT: begin
                    if (alpha || digit) begin
                        n_cand = filter(r_cand, len, i_text_byte);
                        n_pos  = adv;
                        done   = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (digit) begin
                        n_pos = adv;
                        done  = 1'b1;
                    end else if (i_text_byte == 8'h2e) begin
                        n_mode = M_NUM_DOT;
                        n_pos  = adv;
                        done   = 1'b1;
                    end
                end
                M_NUM_DOT, M_FRAC: begin
                    if (digit) begin
                        n_mode = M_FRAC;
                        n_pos  = adv;
                        done   = 1'b1;
                    end
                end
                M_STRING: begin
                    if (i_text_byte == 8'h0a && r_line != 16'hffff)
                        n_line = r_line + 16'd1;
                    n_pos = adv;
                    if (i_text_byte == 8'h22) begin
                        b      = add(b, mk(K_STRING, r_start, adv - r_start, E_NONE));
                        n_mode = M_IDLE;
                    end
                    done = 1'b1;
                end
                M_COMMENT: begin
                    if (i_text_byte != 8'h0a) begin
                        n_pos = adv;
                        done  = 1'b1;
                    end
                end
                M_OP_BANG, M_OP_EQ, M_OP_LT, M_OP_GT: begin
                    if (i_text_byte == 8'h3d) begin
                        case (r_mode)
                            M_OP_BANG: pk = K_BANG_EQ;
                            M_OP_EQ:   pk = K_EQ_EQ;
                            M_OP_LT:   pk = K_LESS_EQ;
                            default:   pk = K_GT_EQ;
                        endcase
                        n_pos  = adv;
                        b      = add(b, mk(pk, r_start, adv - r_start, E_NONE));
                        n_mode = M_IDLE;
                        done   = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (i_end_of_text || !done) begin
            // flush the pending token
            case (r_mode)
                M_IDENT:  b = add(b, mk(ident_kind(r_cand, len), r_start, len, E_NONE));
                M_NUMBER, M_FRAC: b = add(b, mk(K_NUMBER, r_start, len, E_NONE));
                M_NUM_DOT: begin
                    b = add(b, mk(K_NUMBER, r_start, (len != 0) ? len - 16'd1 : 16'd0,
                                  E_NONE));
                    b = add(b, mk(K_DOT, (r_pos != 0) ? r_pos - 16'd1 : 16'd0, 16'd1,
                                  E_NONE));
                end
                M_STRING:  b = add(b, mk(K_ERROR, r_start, len, E_UNTERM));
                M_OP_BANG: b = add(b, mk(K_BANG, r_start, len, E_NONE));
                M_OP_EQ:   b = add(b, mk(K_EQUAL, r_start, len, E_NONE));
                M_OP_LT:   b = add(b, mk(K_LESS, r_start, len, E_NONE));
                M_OP_GT:   b = add(b, mk(K_GREATER, r_start, len, E_NONE));
                default: ;
            endcase
            n_mode = M_IDLE;

            if (i_end_of_text) begin
                b       = add(b, mk(K_EOF, r_pos, 16'd0, E_NONE));
                n_pos   = '0;
                n_start = '0;
                n_line  = 16'd1;
                n_cand  = KW_MASK;
            end else begin
                n_start = r_pos;
                n_pos   = adv;
                case (i_text_byte)
                    8'h0a: begin
                        if (r_line != 16'hffff)
                            n_line = r_line + 16'd1;
                    end
                    8'h20, 8'h0d, 8'h09: ;
                    8'h23: n_mode = M_COMMENT;
                    8'h22: n_mode = M_STRING;
                    8'h21: n_mode = M_OP_BANG;
                    8'h3d: n_mode = M_OP_EQ;
                    8'h3c: n_mode = M_OP_LT;
                    8'h3e: n_mode = M_OP_GT;
                    8'h28: pk = K_LPAREN;
                    8'h29: pk = K_RPAREN;
                    8'h7b: pk = K_LBRACE;
                    8'h7d: pk = K_RBRACE;
                    8'h3b: pk = K_SEMI;
                    8'h2c: pk = K_COMMA;
                    8'h2e: pk = K_DOT;
                    8'h2d: pk = K_MINUS;
                    8'h2b: pk = K_PLUS;
                    8'h2f: pk = K_SLASH;
                    8'h2a: pk = K_STAR;
                    default: begin
                        if (alpha) begin
                            n_mode = M_IDENT;
                            n_cand = filter(KW_MASK, 16'd0, i_text_byte);
                        end else if (digit) begin
                            n_mode = M_NUMBER;
                        end else begin
                            pk = K_ERROR;
                        end
                    end
                endcase
                if (pk != 6'h3f)
                    b = add(b, mk(pk, r_pos, adv - r_pos,
                                  (pk == K_ERROR) ? E_UNEXP : E_NONE));
            end
        end
    end

    assign accept   = i_valid && !i_full;
    assign o_push   = accept && b.cnt != 2'd0;
    assign o_bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_line  <= 16'd1;
            r_cand  <= KW_MASK;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_line  <= n_line;
            r_cand  <= n_cand;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stc_queue.sv -----
// ---------------------------------------------------------------------------
// stc_queue: short word queue between front and back
// lets the classifier run on while the back drains multi-token words
// ---------------------------------------------------------------------------
`default_nettype none

module stc_queue
    import stc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  t_bundle      i_data,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_empty,
    output t_bundle      o_head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_bundle       r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    assign o_full  = r_cnt == (PW + 1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + 1'b1;
            if (i_pop)
                r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stc_back.sv -----
// ---------------------------------------------------------------------------
// stc_back: token serialiser
// sends each word's tokens one a cycle unless stalled, via an output register
// ---------------------------------------------------------------------------
`default_nettype none

module stc_back
    import stc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_empty,
    input  t_bundle       i_head,
    output logic          o_pop,
    input  wire logic     i_stall,
    output logic          o_valid,
    output logic [5:0]    o_token_kind,
    output logic [15:0]   o_token_start,
    output logic [15:0]   o_token_length,
    output logic [15:0]   o_token_line,
    output logic [1:0]    o_error_code,
    output logic          o_last_of_run
);

    logic [1:0] r_idx;
    logic       load;
    logic       last;
    t_token     tk;

    assign load  = !i_empty && (!o_valid || !i_stall);
    assign tk    = i_head.tok[r_idx];
    assign last  = r_idx == i_head.cnt - 2'd1;
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                o_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_token_kind   <= tk.kind;
            o_token_start  <= tk.start;
            o_token_length <= tk.len;
            o_token_line   <= i_head.line;
            o_error_code   <= tk.err;
            o_last_of_run  <= last;
        end
    end

endmodule

`default_nettype wire
